// ===== src/rata_pkg.sv =====
`default_nettype none

package rata_pkg;

  // Field widths fixed by the interface.
  localparam int ELEM_W = 11;
  localparam int DATA_W = 64;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Default capacity and reset value of the element count register.
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam logic [ELEM_W-1:0] ELEMENTS_RESET = 11'd1024;

  // Register index of the element count.
  localparam logic CFG_ELEMENTS_IDX = 1'b0;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ASSIGN = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  // One tree node as it sits in the node memory.
  typedef struct packed {
    logic [DATA_W-1:0] node_max;
    logic [DATA_W-1:0] pend_add;
    logic [DATA_W-1:0] asg_val;
    logic              asg_flag;
  } node_t;

  // Signed maximum of two two's-complement words.
  function automatic logic [DATA_W-1:0] smax(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  // Node after an assignment tag lands on it.
  function automatic node_t put_assign(logic [DATA_W-1:0] x);
    node_t o;
    o.node_max = x;
    o.pend_add = '0;
    o.asg_val  = x;
    o.asg_flag = 1'b1;
    return o;
  endfunction

  // Node after an add tag lands on it; an assignment tag absorbs the add.
  function automatic node_t put_add(node_t w, logic [DATA_W-1:0] x);
    node_t o;
    o = w;
    o.node_max = w.node_max + x;
    if (w.asg_flag) begin
      o.asg_val = w.asg_val + x;
    end else begin
      o.pend_add = w.pend_add + x;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== src/rata_if.sv =====
`default_nettype none

// Request channel.
interface rata_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [rata_pkg::ELEM_W-1:0]      left_index;
  logic [rata_pkg::ELEM_W-1:0]      right_index;
  logic signed [rata_pkg::DATA_W-1:0] operand_value;

  modport source (output valid, req_type, left_index, right_index, operand_value,
                  input ready);
  modport sink (input valid, req_type, left_index, right_index, operand_value,
                output ready);
endinterface

// Result channel.
interface rata_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [rata_pkg::DATA_W-1:0] range_max;
  logic                             status;

  modport source (output valid, range_max, status, input ready);
  modport sink (input valid, range_max, status, output ready);
endinterface

`default_nettype wire

// ===== src/range_assign_add_max_tree_core.sv =====
`default_nettype none
// Operation: a request walks the tree depth first; each node is read, a node inside the range
//   returns its maximum, and a split node passes any pending tags to both children, descends,
//   and on an update gathers the child maxima on the way back; a bad range or the unused
//   request type goes straight to the result register.
// Requests: one at a time; ready is held low until the sequencer is back in idle.
// Reset: after rst the node memory is swept to zero, all 4*MAX_ELEMENTS entries, before the
//   first request is taken; configuration writes are taken throughout.

module range_assign_add_max_tree_core #(
  parameter int MAX_ELEMENTS = rata_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rata_pkg::APB_AW-1:0] paddr,
  input  wire logic [rata_pkg::APB_DW-1:0] pwdata,
  output logic      [rata_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  rata_req_if.sink                         req,
  rata_res_if.source                       res
);

  localparam int DEPTH = 4 * MAX_ELEMENTS;
  localparam int NW    = $clog2(DEPTH);
  localparam int IW    = ($clog2(MAX_ELEMENTS + 1) > rata_pkg::ELEM_W) ?
                         $clog2(MAX_ELEMENTS + 1) : rata_pkg::ELEM_W;
  localparam int SD    = $clog2(MAX_ELEMENTS) + 2;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);
  localparam int DW    = rata_pkg::DATA_W;

  typedef enum logic [1:0] {
    PH_NEW   = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [NW-1:0] p;
    logic [IW-1:0] l;
    logic [IW-1:0] r;
    phase_t        phase;
    logic [DW-1:0] best;
    logic          have;
  } frame_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_NODE, S_SPA1, S_SPA2, S_SPD1, S_SPD2,
    S_DESC, S_RET, S_CONT, S_G1, S_G2, S_OUT
  } state_t;

  state_t                      state;
  logic [rata_pkg::ELEM_W-1:0] cfg_elems;
  logic [NW-1:0]               clr_addr;

  // Request being worked on.
  logic [IW-1:0] ql;
  logic [IW-1:0] qr;
  logic [DW-1:0] op_val;
  logic          is_query;
  logic          is_add;

  // Walk state: current frame and saved ancestors.
  frame_t        cur;
  frame_t        stk [SD];
  logic [SPW-1:0] sp;
  logic [DW-1:0] ret_val;
  logic [DW-1:0] tag_val;
  logic [DW-1:0] gath_a;

  // Result register.
  logic          out_valid;
  logic [DW-1:0] out_max;
  logic          out_status;
  logic [DW-1:0] res_max;
  logic          res_status;

  // Memory control.
  logic            we;
  logic [NW-1:0]   waddr;
  rata_pkg::node_t wdata;
  logic            re;
  logic [NW-1:0]   raddr;
  rata_pkg::node_t rdata;

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rata_pkg::CFG_ELEMENTS_IDX);
  assign prdata = (paddr[2] == rata_pkg::CFG_ELEMENTS_IDX) ?
                  {{(rata_pkg::APB_DW - rata_pkg::ELEM_W){1'b0}}, cfg_elems} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_elems <= rata_pkg::ELEMENTS_RESET;
    end else if (cfg_wr) begin
      cfg_elems <= pwdata[rata_pkg::ELEM_W-1:0];
    end
  end

  // Element count saturated to the capacity.
  logic [IW-1:0] n_eff;
  always_comb begin
    n_eff = IW'(cfg_elems);
    if (n_eff > IW'(MAX_ELEMENTS)) begin
      n_eff = IW'(MAX_ELEMENTS);
    end
  end

  // Range check of an incoming request.
  logic [IW-1:0] in_l;
  logic [IW-1:0] in_r;
  logic          in_bad;
  assign in_l   = IW'(req.left_index);
  assign in_r   = IW'(req.right_index);
  assign in_bad = (n_eff == '0) || (in_l == '0) || (in_r < in_l) || (in_r > n_eff);

  // Split point and children of the current node.
  logic [IW:0]   lr_sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] mid_p1;
  logic [NW-1:0] lp;
  logic [NW-1:0] rp;
  logic          full;
  logic          go_left;
  logic          go_right;
  assign lr_sum   = {1'b0, cur.l} + {1'b0, cur.r};
  assign mid      = lr_sum[IW:1];
  assign mid_p1   = mid + IW'(1);
  assign lp       = {cur.p[NW-2:0], 1'b0};
  assign rp       = {cur.p[NW-2:0], 1'b1};
  assign full     = (ql <= cur.l) && (qr >= cur.r);
  assign go_left  = (ql <= mid);
  assign go_right = (qr > mid);

  logic [SIW-1:0] sp_idx;
  logic [SPW-1:0] sp_m1;
  assign sp_idx = sp[SIW-1:0];
  assign sp_m1  = sp - SPW'(1);

  logic pending_tag;
  assign pending_tag = rdata.asg_flag || (rdata.pend_add != '0);

  // Parent frame after merging, on a query, the value that came back from a child.
  frame_t parent;
  always_comb begin
    parent = stk[sp_m1[SIW-1:0]];
    if (is_query) begin
      parent.best = parent.have ? rata_pkg::smax(parent.best, ret_val) : ret_val;
      parent.have = 1'b1;
    end
  end

  // Frame saved on a descent and the child frame that is entered.
  logic   take_left;
  frame_t saved;
  frame_t child;
  assign take_left = (state == S_DESC) && go_left;
  always_comb begin
    saved       = cur;
    saved.phase = take_left ? PH_LEFT : PH_RIGHT;
    child       = cur;
    child.p     = take_left ? lp : rp;
    child.l     = take_left ? cur.l : mid_p1;
    child.r     = take_left ? mid : cur.r;
    child.phase = PH_NEW;
    child.best  = '0;
    child.have  = 1'b0;
  end

  // Node memory accesses of each step.
  always_comb begin
    we    = 1'b0;
    waddr = cur.p;
    wdata = '0;
    re    = 1'b0;
    raddr = cur.p;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_READ: begin
        re = 1'b1;
      end
      S_NODE: begin
        if (full) begin
          if (!is_query) begin
            we    = 1'b1;
            wdata = is_add ? rata_pkg::put_add(rdata, op_val) : rata_pkg::put_assign(op_val);
          end
        end else if (pending_tag) begin
          // The tags move down; the node keeps its maximum.
          we             = 1'b1;
          wdata          = rdata;
          wdata.pend_add = '0;
          wdata.asg_flag = 1'b0;
          if (!rdata.asg_flag) begin
            re    = 1'b1;
            raddr = lp;
          end
        end
      end
      S_SPA1: begin
        we    = 1'b1;
        waddr = lp;
        wdata = rata_pkg::put_assign(tag_val);
      end
      S_SPA2: begin
        we    = 1'b1;
        waddr = rp;
        wdata = rata_pkg::put_assign(tag_val);
      end
      S_SPD1: begin
        we    = 1'b1;
        waddr = lp;
        wdata = rata_pkg::put_add(rdata, tag_val);
        re    = 1'b1;
        raddr = rp;
      end
      S_SPD2: begin
        we    = 1'b1;
        waddr = rp;
        wdata = rata_pkg::put_add(rdata, tag_val);
      end
      S_CONT: begin
        if (!(cur.phase == PH_LEFT && go_right) && !is_query) begin
          re    = 1'b1;
          raddr = lp;
        end
      end
      S_G1: begin
        re    = 1'b1;
        raddr = rp;
      end
      S_G2: begin
        we             = 1'b1;
        wdata.node_max = rata_pkg::smax(gath_a, rdata.node_max);
      end
      default: begin
      end
    endcase
  end

  rata_node_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE);

  // Sequencer: walks the tree one node step at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      sp         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == NW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            ql       <= in_l;
            qr       <= in_r;
            op_val   <= req.operand_value;
            is_query <= (req.req_type == rata_pkg::REQ_QUERY);
            is_add   <= (req.req_type == rata_pkg::REQ_ADD);
            res_max  <= '0;
            sp       <= '0;
            if (req.req_type == rata_pkg::REQ_NONE) begin
              res_status <= rata_pkg::STATUS_OK;
              state      <= S_OUT;
            end else if (in_bad) begin
              res_status <= rata_pkg::STATUS_BAD;
              state      <= S_OUT;
            end else begin
              cur.p     <= NW'(1);
              cur.l     <= IW'(1);
              cur.r     <= n_eff;
              cur.phase <= PH_NEW;
              cur.best  <= '0;
              cur.have  <= 1'b0;
              state     <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_NODE;
        end
        S_NODE: begin
          if (full) begin
            ret_val <= rdata.node_max;
            state   <= S_RET;
          end else if (rdata.asg_flag) begin
            tag_val <= rdata.asg_val;
            state   <= S_SPA1;
          end else if (rdata.pend_add != '0) begin
            tag_val <= rdata.pend_add;
            state   <= S_SPD1;
          end else begin
            state <= S_DESC;
          end
        end
        S_SPA1: begin
          state <= S_SPA2;
        end
        S_SPA2: begin
          state <= S_DESC;
        end
        S_SPD1: begin
          state <= S_SPD2;
        end
        S_SPD2: begin
          state <= S_DESC;
        end
        S_DESC: begin
          // Save this node and step into the first child that meets the range.
          stk[sp_idx] <= saved;
          sp          <= sp + SPW'(1);
          cur         <= child;
          state       <= S_READ;
        end
        S_RET: begin
          if (sp == '0) begin
            res_max    <= is_query ? ret_val : '0;
            res_status <= rata_pkg::STATUS_OK;
            state      <= S_OUT;
          end else begin
            cur   <= parent;
            sp    <= sp_m1;
            state <= S_CONT;
          end
        end
        S_CONT: begin
          if (cur.phase == PH_LEFT && go_right) begin
            stk[sp_idx] <= saved;
            sp          <= sp + SPW'(1);
            cur         <= child;
            state       <= S_READ;
          end else if (is_query) begin
            ret_val <= cur.best;
            state   <= S_RET;
          end else begin
            state <= S_G1;
          end
        end
        S_G1: begin
          gath_a <= rdata.node_max;
          state  <= S_G2;
        end
        S_G2: begin
          state <= S_RET;
        end
        S_OUT: begin
          if (!out_valid || res.ready) begin
            out_max    <= res_max;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid     = out_valid;
  assign res.range_max = out_max;
  assign res.status    = out_status;

  // The ancestor stack never overflows.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp < SPW'(SD))
    else $error("ancestor stack overflow");

  // A new request always starts from an empty stack.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sp == '0))
    else $error("stack not empty when idle");

  // A read never targets the entry written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write of one node in one cycle");

  // An accepted request leaves the idle state.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request transfer did not start work");

endmodule

`default_nettype wire

// ===== src/rata_node_ram.sv =====
`default_nettype none

// Simple dual-port node memory: one write and one registered read per cycle.
module rata_node_ram #(
  parameter int DEPTH = 4 * rata_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire rata_pkg::node_t          wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output rata_pkg::node_t               rdata
);

  rata_pkg::node_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int TREE_SLOTS = 4 * rata_pkg::MAX_ELEMENTS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [rata_pkg::DATA_W-1:0] range_max;
    logic                        status;
  } tree_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rata_pkg::APB_AW-1:0] paddr;
  logic [rata_pkg::APB_DW-1:0] pwdata;
  logic [rata_pkg::APB_DW-1:0] prdata;
  logic pready;

  rata_req_if req ();
  rata_res_if res ();

  range_assign_add_max_tree_core DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .res(res.source)
  );

  // Shadow tree and configuration kept by the predictor.
  logic [rata_pkg::DATA_W-1:0] tree_max [TREE_SLOTS];
  logic [rata_pkg::DATA_W-1:0] tree_add [TREE_SLOTS];
  logic [rata_pkg::DATA_W-1:0] tree_asg [TREE_SLOTS];
  logic                        tree_asg_on [TREE_SLOTS];
  logic [rata_pkg::ELEM_W-1:0] element_count;

  tree_result_t expected_results [$];
  int mismatch_count;
  int idle_cycles;
  bit calm;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [rata_pkg::DATA_W-1:0] larger(logic [rata_pkg::DATA_W-1:0] a,
                                                         logic [rata_pkg::DATA_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic void tag_assign(int p, logic [rata_pkg::DATA_W-1:0] x);
    if (p >= TREE_SLOTS) return;
    tree_max[p] = x;
    tree_asg_on[p] = 1'b1;
    tree_asg[p] = x;
    tree_add[p] = '0;
  endfunction

  function automatic void tag_add(int p, logic [rata_pkg::DATA_W-1:0] x);
    if (p >= TREE_SLOTS) return;
    tree_max[p] = tree_max[p] + x;
    if (tree_asg_on[p]) tree_asg[p] = tree_asg[p] + x;
    else tree_add[p] = tree_add[p] + x;
  endfunction

  // Hand the node's pending tags down to both children.
  function automatic void spread_tags(int p);
    if (p >= TREE_SLOTS) return;
    if (tree_asg_on[p]) begin
      tag_assign(2 * p, tree_asg[p]);
      tag_assign(2 * p + 1, tree_asg[p]);
      tree_asg_on[p] = 1'b0;
    end
    if (tree_add[p] != '0) begin
      tag_add(2 * p, tree_add[p]);
      tag_add(2 * p + 1, tree_add[p]);
      tree_add[p] = '0;
    end
  endfunction

  function automatic void range_update(bit is_add, int ql, int qr,
                                       logic [rata_pkg::DATA_W-1:0] x,
                                       int p, int l, int r);
    int mid;
    if (p >= TREE_SLOTS) return;
    if (ql <= l && qr >= r) begin
      if (is_add) tag_add(p, x);
      else tag_assign(p, x);
      return;
    end
    spread_tags(p);
    mid = (l + r) >> 1;
    if (ql <= mid) range_update(is_add, ql, qr, x, 2 * p, l, mid);
    if (qr > mid) range_update(is_add, ql, qr, x, 2 * p + 1, mid + 1, r);
    if (2 * p + 1 < TREE_SLOTS) tree_max[p] = larger(tree_max[2 * p], tree_max[2 * p + 1]);
  endfunction

  function automatic logic [rata_pkg::DATA_W-1:0] range_maximum(int ql, int qr, int p,
                                                                int l, int r);
    int mid;
    logic [rata_pkg::DATA_W-1:0] best;
    bit have;
    best = '0;
    have = 0;
    if (p >= TREE_SLOTS) return '0;
    if (ql <= l && qr >= r) return tree_max[p];
    spread_tags(p);
    mid = (l + r) >> 1;
    if (ql <= mid) begin
      best = range_maximum(ql, qr, 2 * p, l, mid);
      have = 1;
    end
    if (qr > mid) begin
      if (have) best = larger(best, range_maximum(ql, qr, 2 * p + 1, mid + 1, r));
      else best = range_maximum(ql, qr, 2 * p + 1, mid + 1, r);
    end
    return best;
  endfunction

  // Apply one request to the shadow tree and return what the block must answer.
  function automatic tree_result_t apply_request(rata_pkg::req_kind_t kind, int left,
                                                 int right,
                                                 logic [rata_pkg::DATA_W-1:0] x);
    tree_result_t o;
    int n;
    n = (element_count > rata_pkg::MAX_ELEMENTS_DEF) ? rata_pkg::MAX_ELEMENTS_DEF
                                                     : element_count;
    o.range_max = '0;
    o.status = rata_pkg::STATUS_OK;
    if (kind == rata_pkg::REQ_NONE) return o;
    if (n == 0 || left == 0 || right < left || right > n) begin
      o.status = rata_pkg::STATUS_BAD;
      return o;
    end
    if (kind == rata_pkg::REQ_QUERY) o.range_max = range_maximum(left, right, 1, 1, n);
    else range_update(kind == rata_pkg::REQ_ADD, left, right, x, 1, 1, n);
    return o;
  endfunction

  // Send one request; the expectation is recorded at the transfer edge.
  task automatic send_request(rata_pkg::req_kind_t kind, int left, int right,
                              logic [rata_pkg::DATA_W-1:0] x);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.req_type = kind;
    req.left_index = left[rata_pkg::ELEM_W-1:0];
    req.right_index = right[rata_pkg::ELEM_W-1:0];
    req.operand_value = x;
    do @(posedge clk); while (!req.ready);
    expected_results.push_back(apply_request(kind, left, right, x));
  endtask

  task automatic end_requests();
    @(negedge clk);
    req.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the element count once the block has answered everything.
  task automatic set_element_count(logic [rata_pkg::ELEM_W-1:0] value);
    end_requests();
    repeat (5) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = rata_pkg::APB_AW'(rata_pkg::CFG_ELEMENTS_IDX) << 2;
    pwdata = rata_pkg::APB_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    element_count = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [rata_pkg::DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int active_count();
    return (element_count > rata_pkg::MAX_ELEMENTS_DEF) ? rata_pkg::MAX_ELEMENTS_DEF
                                                        : element_count;
  endfunction

  // Result side: random back-pressure, compared against the oldest expectation.
  initial begin
    int stall;
    res.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (stall > 0) begin
        res.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready = 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  always @(posedge clk) begin
    tree_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result: max %0d status %0d",
                                           $signed(res.range_max), res.status);
      end else begin
        want = expected_results.pop_front();
        if (res.range_max !== want.range_max || res.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected max %0d status %0d, got max %0d status %0d",
                     $signed(want.range_max), want.status, $signed(res.range_max),
                     res.status);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // A fresh tree reads as zero everywhere.
  task automatic test_cleared_tree();
    send_request(rata_pkg::REQ_QUERY, 1, 1024, random_word());
    send_request(rata_pkg::REQ_QUERY, 512, 513, '0);
  endtask

  // Field extremes, every request kind and each bad range.
  task automatic test_directed();
    send_request(rata_pkg::REQ_ASSIGN, 1, 1, 64'h8000_0000_0000_0000);
    send_request(rata_pkg::REQ_ASSIGN, 1024, 1024, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(rata_pkg::REQ_QUERY, 1, 1024, '0);
    send_request(rata_pkg::REQ_ADD, 1000, 1024, 64'd1);
    send_request(rata_pkg::REQ_QUERY, 1, 1024, '1);
    send_request(rata_pkg::REQ_ASSIGN, 2, 1023, '1);
    send_request(rata_pkg::REQ_ADD, 1, 1024, 64'h8000_0000_0000_0000);
    send_request(rata_pkg::REQ_QUERY, 1, 1, '0);
    send_request(rata_pkg::REQ_QUERY, 3, 700, '0);
    send_request(rata_pkg::REQ_ADD, 5, 9, 64'd3);
    send_request(rata_pkg::REQ_ASSIGN, 6, 8, -64'sd5);
    send_request(rata_pkg::REQ_ADD, 1, 1024, 64'd2);
    send_request(rata_pkg::REQ_QUERY, 4, 10, '0);
    send_request(rata_pkg::REQ_QUERY, 7, 7, '0);
    send_request(rata_pkg::REQ_QUERY, 0, 5, '0);
    send_request(rata_pkg::REQ_ADD, 9, 8, 64'd1);
    send_request(rata_pkg::REQ_ASSIGN, 1, 1025, 64'd1);
    send_request(rata_pkg::REQ_QUERY, 2047, 2047, '0);
    send_request(rata_pkg::REQ_NONE, 1, 10, random_word());
    send_request(rata_pkg::REQ_QUERY, 1, 1024, '0);
  endtask

  // Mostly well-formed ranges with random content, some noise mixed in.
  task automatic test_random_phase(logic [rata_pkg::ELEM_W-1:0] count, int items);
    int n, a, b, kind;
    set_element_count(count);
    n = active_count();
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 25) calm = !calm;
      kind = $urandom_range(0, 19);
      if (n == 0 || kind == 19) begin
        send_request(rata_pkg::req_kind_t'($urandom_range(0, 3)), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), random_word());
      end else begin
        a = $urandom_range(1, n);
        b = ($urandom_range(0, 2) == 0) ? a : $urandom_range(1, n);
        if (b < a) begin
          kind = a;
          a = b;
          b = kind;
        end
        case ($urandom_range(0, 5))
          0, 1: send_request(rata_pkg::REQ_QUERY, a, b, random_word());
          2: send_request(rata_pkg::REQ_ADD, a, b, ($urandom_range(0, 3) == 0) ? random_word()
                          : 64'($signed($urandom_range(0, 200)) - 100));
          3: send_request(rata_pkg::REQ_ADD, a, b, random_word());
          default: send_request(rata_pkg::REQ_ASSIGN, a, b, random_word());
        endcase
      end
    end
    calm = 0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.req_type = rata_pkg::REQ_ASSIGN;
    req.left_index = '0;
    req.right_index = '0;
    req.operand_value = '0;
    calm = 0;
    element_count = rata_pkg::ELEMENTS_RESET;
    for (int p = 0; p < TREE_SLOTS; p++) begin
      tree_max[p] = '0;
      tree_add[p] = '0;
      tree_asg[p] = '0;
      tree_asg_on[p] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_cleared_tree();
    test_directed();
    test_random_phase(11'd1024, 250);
    test_random_phase(11'd1, 40);
    test_random_phase(11'd2, 60);
    test_random_phase(11'd13, 200);
    test_random_phase(11'd0, 20);
    test_random_phase(11'd2047, 100);
    test_random_phase(11'd100, 160);
    test_random_phase(11'd777, 100);
    end_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
